// ----- hdl/cap_pkg.sv -----
// ----------------------------------------------------------------------------
// cap_pkg - shared types, constants and fixed point helpers
// Q16.16 saturating arithmetic, request payloads and configuration set for
// the cascaded attitude controller and motor mixer.
// ----------------------------------------------------------------------------
package cap_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = 32 + FRAC_BITS;
    localparam int DIV_CW    = $clog2(DIV_W);

    localparam logic signed [31:0] S32_MAX    = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN    = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE      = 32'(2 ** FRAC_BITS);
    localparam logic signed [31:0] K_EXPO     = 32'((5 * (2 ** FRAC_BITS) + 50) / 100);
    localparam logic signed [31:0] K_THR_LO   = 32'(1000 * (2 ** FRAC_BITS));
    localparam logic signed [31:0] K_THR_HI   = 32'(1650 * (2 ** FRAC_BITS));
    localparam logic signed [31:0] K_SCALE_HI = 32'((12 * (2 ** FRAC_BITS) + 5) / 10);
    localparam logic signed [31:0] K_LIM_BASE = 32'(10 * (2 ** FRAC_BITS));

    // x / 6500 taken as ((x >> 2) * ceil(2^38 / 1625)) >> 38, exact over the
    // clamped throttle span
    localparam int          SCALE_SHIFT   = 38;
    localparam logic [27:0] K_SCALE_RECIP =
        28'(((64'd1 << SCALE_SHIFT) + 64'd1624) / 64'd1625);

    typedef struct packed {
        logic [16:0]        time_step;
        logic signed [31:0] base_throttle;
        logic signed [31:0] roll_setpoint;
        logic signed [31:0] pitch_setpoint;
        logic signed [31:0] yaw_correction;
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] roll_rate;
        logic signed [31:0] pitch_rate;
    } in_t;

    typedef struct packed {
        logic [15:0] motor_front_left;
        logic [15:0] motor_front_right;
        logic [15:0] motor_rear_left;
        logic [15:0] motor_rear_right;
    } out_t;

    typedef struct packed {
        logic [23:0] angle_kp;
        logic [23:0] rate_kp;
        logic [23:0] rate_ki;
        logic [23:0] rate_kd;
        logic [16:0] rate_d_filter;
        logic [30:0] angle_rate_limit;
        logic [15:0] motor_min;
        logic [15:0] motor_max;
    } cfg_t;

    typedef enum logic [2:0] {
        CFG_ANGLE_KP, CFG_RATE_KP, CFG_RATE_KI, CFG_RATE_KD,
        CFG_RATE_D_FILTER, CFG_ANGLE_RATE_LIMIT, CFG_MOTOR_MIN, CFG_MOTOR_MAX
    } cfg_idx_t;

    typedef enum logic [4:0] {
        LN_IDLE, LN_ERR, LN_EXPO, LN_SHAPE, LN_WANT, LN_RATE_E, LN_IMUL,
        LN_LIM, LN_LIMADD, LN_ICLAMP, LN_F1, LN_F2, LN_F3, LN_P, LN_I,
        LN_D, LN_OUT, LN_DONE
    } lane_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE, TOP_LOAD, TOP_LANES, TOP_MIX
    } top_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sd2147483647)
                r = S32_MAX;
            else if (v < -66'sd2147483648)
                r = S32_MIN;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    // product rounded toward minus infinity, then saturated
    function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        begin
            p = 66'(a) * 66'(b);
            return sat32(p >>> FRAC_BITS);
        end
    endfunction

    function automatic logic signed [31:0] clampsym(input logic signed [31:0] v,
                                                    input logic [31:0] lim);
        logic signed [33:0] vv;
        logic signed [33:0] ll;
        logic signed [31:0] r;
        begin
            vv = 34'(v);
            ll = $signed({2'b00, lim});
            if (vv > ll)
                r = $signed(lim);
            else if (vv < -ll)
                r = 32'(-ll);
            else
                r = v;
            return r;
        end
    endfunction

endpackage

// ----- hdl/cascaded_attitude_pid_mixer.sv -----
// ----------------------------------------------------------------------------
// cascaded_attitude_pid_mixer - attitude controller with X-frame mixer
// Roll and pitch lanes run the angle and rate loops side by side; a mixer
// merges their corrections into four motor commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one control tick per
//   request. in_stall stays high from the accepting edge until the result
//   sits in the output register, so one request is in flight at a time.
//   Output channel (out_valid / out_stall / out_data) gives one request of
//   four motor commands per tick, held in an output register until taken.
//   A new tick is accepted while that result still waits downstream.
//   From accept to out_valid: the lanes and the throttle scale are loaded,
//   each lane's bit-serial divider for the derivative sets the pace, the
//   lane steps F3, P, I, D and OUT follow, then the mixer is started, three
//   mixer steps run and the result moves into the output register.
//   If the receiver stalls when a result is ready and the output register
//   is still full, hold the finished result in the mixer until it frees;
//   in_stall stays high meanwhile.
//   Reset clears the integrators, derivative history and previous rates,
//   and loads the configuration defaults. Configuration writes through
//   cfg_write / cfg_index / cfg_data land in cfg_reg directly and are seen by a tick already in flight.
// ----------------------------------------------------------------------------
module cascaded_attitude_pid_mixer
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  cap_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output cap_pkg::out_t out_data,
    input  logic          cfg_write,
    input  logic [2:0]    cfg_index,
    input  logic [30:0]   cfg_data
);
    import cap_pkg::*;

    top_state_t state_reg, state_next;
    cfg_t       cfg_reg;
    in_t        in_reg;
    out_t       out_reg;
    logic       out_valid_reg;

    logic               in_accept;
    logic               lanes_start, mix_start, out_load;
    logic               roll_done, pitch_done, mix_done;
    logic               scale_done_reg;
    logic signed [31:0] roll_corr, pitch_corr, scale_reg;
    logic signed [31:0] thr_c;
    logic [31:0]        thr_span;
    logic [31:0]        span_reg;
    logic [57:0]        scale_prod;
    logic [16:0]        scale_q;
    out_t               mix_result;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != TOP_IDLE);

    // throttle scale numerator: clamp to the throttle band, times 11
    always_comb
    begin
        if (in_data.base_throttle < K_THR_LO)
            thr_c = K_THR_LO;
        else if (in_data.base_throttle > K_THR_HI)
            thr_c = K_THR_HI;
        else
            thr_c = in_data.base_throttle;
        thr_span = 32'(thr_c - K_THR_LO) * 32'd11;
    end

    // divide the span by 6500 through a reciprocal multiply
    assign scale_prod = 58'(span_reg[31:2]) * 58'(K_SCALE_RECIP);
    assign scale_q    = scale_prod[SCALE_SHIFT +: 17];

    cap_lane u_roll
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (lanes_start),
        .cfg         (cfg_reg),
        .time_step   (in_reg.time_step),
        .setpoint    (in_reg.roll_setpoint),
        .angle       (in_reg.roll_angle),
        .rate        (in_reg.roll_rate),
        .scale       (scale_reg),
        .scale_valid (scale_done_reg),
        .done        (roll_done),
        .corr        (roll_corr)
    );

    cap_lane u_pitch
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (lanes_start),
        .cfg         (cfg_reg),
        .time_step   (in_reg.time_step),
        .setpoint    (in_reg.pitch_setpoint),
        .angle       (in_reg.pitch_angle),
        .rate        (in_reg.pitch_rate),
        .scale       (scale_reg),
        .scale_valid (scale_done_reg),
        .done        (pitch_done),
        .corr        (pitch_corr)
    );

    cap_mix u_mix
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mix_start),
        .cfg        (cfg_reg),
        .throttle   (in_reg.base_throttle),
        .yaw        (in_reg.yaw_correction),
        .roll_corr  (roll_corr),
        .pitch_corr (pitch_corr),
        .done       (mix_done),
        .result     (mix_result)
    );

    // sequence: load, lanes, then mixer, then advance into the output register
    always_comb
    begin
        state_next  = state_reg;
        lanes_start = 1'b0;
        mix_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            TOP_IDLE:
                if (in_accept)
                    state_next = TOP_LOAD;
            TOP_LOAD:
            begin
                // the request is in in_reg now; start both lanes on it
                lanes_start = 1'b1;
                state_next  = TOP_LANES;
            end
            TOP_LANES:
                if (roll_done && pitch_done)
                begin
                    mix_start  = 1'b1;
                    state_next = TOP_MIX;
                end
            TOP_MIX:
                if (mix_done && (!out_valid_reg || !out_stall))
                begin
                    out_load   = 1'b1;
                    state_next = TOP_IDLE;
                end
            default:
                state_next = TOP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= TOP_IDLE;
            out_valid_reg  <= 1'b0;
            scale_done_reg <= 1'b0;
            cfg_reg.angle_kp         <= 24'd196608;
            cfg_reg.rate_kp          <= 24'd7864;
            cfg_reg.rate_ki          <= 24'd1311;
            cfg_reg.rate_kd          <= 24'd197;
            cfg_reg.rate_d_filter    <= 17'd45875;
            cfg_reg.angle_rate_limit <= 31'd9830400;
            cfg_reg.motor_min        <= 16'd1000;
            cfg_reg.motor_max        <= 16'd2000;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
                scale_done_reg <= 1'b0;
            else if (state_reg == TOP_LOAD)
                scale_done_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ANGLE_KP:         cfg_reg.angle_kp         <= cfg_data[23:0];
                    CFG_RATE_KP:          cfg_reg.rate_kp          <= cfg_data[23:0];
                    CFG_RATE_KI:          cfg_reg.rate_ki          <= cfg_data[23:0];
                    CFG_RATE_KD:          cfg_reg.rate_kd          <= cfg_data[23:0];
                    CFG_RATE_D_FILTER:    cfg_reg.rate_d_filter    <= cfg_data[16:0];
                    CFG_ANGLE_RATE_LIMIT: cfg_reg.angle_rate_limit <= cfg_data[30:0];
                    CFG_MOTOR_MIN:        cfg_reg.motor_min        <= cfg_data[15:0];
                    CFG_MOTOR_MAX:        cfg_reg.motor_max        <= cfg_data[15:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_reg   <= in_data;
            span_reg <= thr_span;
        end
        if (state_reg == TOP_LOAD)
            scale_reg <= K_SCALE_HI - $signed({15'b0, scale_q});
        if (out_load)
            out_reg <= mix_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // the throttle scale is rebuilt for every tick, so its old value drops
    a_scale_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !scale_done_reg)
        else $error("throttle scale still valid right after a new tick");

    a_mix_follows_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == TOP_LANES && roll_done && pitch_done) |=> !mix_done)
        else $error("mixer did not restart when both lanes finished");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && state_reg == TOP_IDLE)
        else $error("finished result did not reach the output register");

endmodule

// ----- hdl/cap_div.sv -----
// ----------------------------------------------------------------------------
// cap_div - restoring divider, one quotient bit per cycle
// Unsigned DIV_W-bit dividend by 17-bit divisor; done stays high until the
// next start.
// ----------------------------------------------------------------------------
module cap_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cap_pkg::DIV_W-1:0] dividend,
    input  logic [16:0]               divisor,
    output logic                      done,
    output logic [cap_pkg::DIV_W-1:0] quotient
);
    import cap_pkg::*;

    logic [DIV_W-1:0]  dvd_reg;
    logic [16:0]       den_reg;
    logic [16:0]       rem_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [17:0] rem_sh;
    logic        ge;
    logic [17:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[DIV_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
            rem_reg <= rem_next[16:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- hdl/cap_lane.sv -----
// ----------------------------------------------------------------------------
// cap_lane - one axis of the cascaded controller
// Angle P loop with expo shaping feeding a rate PID, stepped through one
// shared multiplier; the derivative quotient runs on a private divider.
// ----------------------------------------------------------------------------
module cap_lane
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  cap_pkg::cfg_t             cfg,
    input  logic [16:0]               time_step,
    input  logic signed [31:0]        setpoint,
    input  logic signed [31:0]        angle,
    input  logic signed [31:0]        rate,
    input  logic signed [31:0]        scale,
    input  logic                      scale_valid,
    output logic                      done,
    output logic signed [31:0]        corr
);
    import cap_pkg::*;

    lane_state_t state_reg, state_next;

    logic signed [31:0] prod_reg;
    logic signed [31:0] err_reg, aerr_reg, a19_reg, e_reg, isum_reg, lim_reg;
    logic signed [31:0] f1_reg, filt_reg, acc_reg, corr_reg;
    logic signed [31:0] integ_reg, prev_rate_reg, prev_d_reg;
    logic               dneg_reg, dzero_reg;

    logic signed [32:0] mul_a, mul_b;
    logic               prod_load;

    logic signed [31:0] err_c, num_c, raw_c;
    logic [31:0]        num_mag;
    logic [16:0]        kf;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;

    assign err_c   = sat32(66'(setpoint) - 66'(angle));
    assign num_c   = sat32(66'(rate) - 66'(prev_rate_reg));
    assign num_mag = num_c[31] ? (~num_c + 32'd1) : num_c;
    assign kf      = (cfg.rate_d_filter > 17'(Q_ONE)) ? 17'(Q_ONE) : cfg.rate_d_filter;

    cap_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend ({num_mag, {FRAC_BITS{1'b0}}}),
        .divisor  (time_step),
        .done     (div_done),
        .quotient (div_q)
    );

    // zero interval: saturated extreme with the sign of the rate change, or zero if the rate did not change
    always_comb
    begin
        if (time_step == '0)
            raw_c = dzero_reg ? 32'sd0 : (dneg_reg ? S32_MIN : S32_MAX);
        else if (dneg_reg)
            raw_c = (div_q > DIV_W'(64'd2147483648)) ? S32_MIN : $signed(-div_q[31:0]);
        else
            raw_c = (div_q > DIV_W'(64'd2147483647)) ? S32_MAX : $signed(div_q[31:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        prod_load  = 1'b0;
        mul_a      = 33'(err_reg);
        mul_b      = 33'(err_reg);
        case (state_reg)
            LN_IDLE, LN_DONE:
                if (start)
                    state_next = LN_ERR;
            LN_ERR:
                state_next = LN_EXPO;
            LN_EXPO:
            begin
                mul_a      = 33'(K_EXPO);
                mul_b      = 33'(aerr_reg);
                prod_load  = 1'b1;
                state_next = LN_SHAPE;
            end
            LN_SHAPE:
            begin
                mul_a      = 33'(err_reg);
                mul_b      = 33'(sat32(66'(Q_ONE) + 66'(prod_reg)));
                prod_load  = 1'b1;
                state_next = LN_WANT;
            end
            LN_WANT:
            begin
                mul_a      = $signed({9'b0, cfg.angle_kp});
                mul_b      = 33'(prod_reg);
                prod_load  = 1'b1;
                state_next = LN_RATE_E;
            end
            LN_RATE_E:
                state_next = LN_IMUL;
            LN_IMUL:
            begin
                mul_a      = 33'(e_reg);
                mul_b      = $signed({16'b0, time_step});
                prod_load  = 1'b1;
                state_next = LN_LIM;
            end
            LN_LIM:
                if (scale_valid)
                begin
                    mul_a      = 33'(a19_reg);
                    mul_b      = 33'(scale);
                    prod_load  = 1'b1;
                    state_next = LN_LIMADD;
                end
            LN_LIMADD:
                state_next = LN_ICLAMP;
            LN_ICLAMP:
                state_next = LN_F1;
            LN_F1:
            begin
                mul_a      = $signed({16'b0, kf});
                mul_b      = 33'(prev_d_reg);
                prod_load  = 1'b1;
                state_next = LN_F2;
            end
            LN_F2:
                if (div_done)
                begin
                    mul_a      = 33'(Q_ONE) - $signed({16'b0, kf});
                    mul_b      = 33'(raw_c);
                    prod_load  = 1'b1;
                    state_next = LN_F3;
                end
            LN_F3:
                state_next = LN_P;
            LN_P:
            begin
                mul_a      = $signed({9'b0, cfg.rate_kp});
                mul_b      = 33'(e_reg);
                prod_load  = 1'b1;
                state_next = LN_I;
            end
            LN_I:
            begin
                mul_a      = $signed({9'b0, cfg.rate_ki});
                mul_b      = 33'(integ_reg);
                prod_load  = 1'b1;
                state_next = LN_D;
            end
            LN_D:
            begin
                mul_a      = $signed({9'b0, cfg.rate_kd});
                mul_b      = 33'(filt_reg);
                prod_load  = 1'b1;
                state_next = LN_OUT;
            end
            LN_OUT:
                state_next = LN_DONE;
            default:
                state_next = LN_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LN_IDLE;
            integ_reg     <= '0;
            prev_rate_reg <= '0;
            prev_d_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == LN_ICLAMP)
                integ_reg <= clampsym(isum_reg, lim_reg);
            if (state_reg == LN_F3)
            begin
                prev_d_reg    <= sat32(66'(f1_reg) + 66'(prod_reg));
                prev_rate_reg <= rate;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_load)
            prod_reg <= qmul(mul_a, mul_b);
        if ((state_reg == LN_IDLE || state_reg == LN_DONE) && start)
        begin
            dneg_reg  <= num_c[31];
            dzero_reg <= (num_c == 32'sd0);
        end
        case (state_reg)
            LN_ERR:
            begin
                err_reg  <= err_c;
                aerr_reg <= err_c[31] ? sat32(-66'(err_c)) : err_c;
            end
            LN_EXPO:
                a19_reg <= sat32(66'(aerr_reg) * 66'sd19);
            LN_RATE_E:
                e_reg <= sat32(66'(clampsym(prod_reg, {1'b0, cfg.angle_rate_limit}))
                               - 66'(rate));
            LN_LIM:
                if (scale_valid)
                    isum_reg <= sat32(66'(integ_reg) + 66'(prod_reg));
            LN_LIMADD:
                lim_reg <= sat32(66'(K_LIM_BASE) + 66'(prod_reg));
            LN_F2:
                if (div_done)
                    f1_reg <= prod_reg;
            LN_F3:
                filt_reg <= sat32(66'(f1_reg) + 66'(prod_reg));
            LN_I:
                acc_reg <= prod_reg;
            LN_D:
                acc_reg <= sat32(66'(acc_reg) + 66'(prod_reg));
            LN_OUT:
                corr_reg <= clampsym(sat32(66'(acc_reg) - 66'(prod_reg)), lim_reg);
            default:
                ;
        endcase
    end

    assign done = (state_reg == LN_DONE);
    assign corr = corr_reg;

endmodule

// ----- hdl/cap_mix.sv -----
// ----------------------------------------------------------------------------
// cap_mix - X-frame motor mixer
// Merge the roll and pitch corrections with throttle and yaw step by
// step, then clamp to the motor range and drop the fraction.
// ----------------------------------------------------------------------------
module cap_mix
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cap_pkg::cfg_t      cfg,
    input  logic signed [31:0] throttle,
    input  logic signed [31:0] yaw,
    input  logic signed [31:0] roll_corr,
    input  logic signed [31:0] pitch_corr,
    output logic               done,
    output cap_pkg::out_t      result
);
    import cap_pkg::*;

    // motor order: front left, front right, rear left, rear right
    localparam logic [3:0] P_NEG = 4'b1010;
    localparam logic [3:0] R_NEG = 4'b1100;
    localparam logic [3:0] Y_NEG = 4'b1001;

    function automatic logic signed [31:0] addsub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic neg);
        begin
            return neg ? sat32(66'(a) - 66'(b)) : sat32(66'(a) + 66'(b));
        end
    endfunction

    function automatic logic [15:0] motor_out(input logic signed [31:0] v,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
        logic signed [65:0] vv;
        logic signed [65:0] lo_q;
        logic signed [65:0] hi_q;
        logic [15:0]        r;
        begin
            vv   = 66'(v);
            lo_q = $signed(66'(lo) << FRAC_BITS);
            hi_q = $signed(66'(hi) << FRAC_BITS);
            if (vv < lo_q)
                r = lo;
            else if (vv > hi_q)
                r = hi;
            else
                r = vv[FRAC_BITS+15:FRAC_BITS];
            return r;
        end
    endfunction

    logic signed [31:0] m_reg [4];
    logic [15:0]        mot_reg [4];
    logic [1:0]         step_reg;
    logic               busy_reg;
    logic               done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= 2'd1;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (start)
                m_reg[i] <= addsub(throttle, pitch_corr, P_NEG[i]);
            else if (busy_reg)
            begin
                case (step_reg)
                    2'd1:    m_reg[i] <= addsub(m_reg[i], roll_corr, R_NEG[i]);
                    2'd2:    m_reg[i] <= addsub(m_reg[i], yaw, Y_NEG[i]);
                    2'd3:    mot_reg[i] <= motor_out(m_reg[i], cfg.motor_min, cfg.motor_max);
                    default: ;
                endcase
            end
        end
    end

    assign done                     = done_reg;
    assign result.motor_front_left  = mot_reg[0];
    assign result.motor_front_right = mot_reg[1];
    assign result.motor_rear_left   = mot_reg[2];
    assign result.motor_rear_right  = mot_reg[3];

endmodule
